// ===== design/ftok_pkg.sv =====
// Shared types and constants for the Forth source tokenizer.
// No dependencies; used by every module of the block but the input register, and by the checker.
`default_nettype none

package ftok_pkg;

    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [1:0] KIND_SKIP = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_STR  = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNTERM  = 2'd1;
    localparam logic [1:0] ERR_NOSPACE = 2'd2;
    localparam logic [1:0] ERR_HALTED  = 2'd3;

    typedef enum logic [6:0] {
        MODE_IDLE     = 7'b000_0001,
        MODE_COMMENT  = 7'b000_0010,
        MODE_WORD     = 7'b000_0100,
        MODE_STRING   = 7'b000_1000,
        MODE_ESC      = 7'b001_0000,
        MODE_AFTERSTR = 7'b010_0000,
        MODE_HALTED   = 7'b100_0000
    } lex_mode_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       starts_token;
        logic       closes_before;
        logic       closes_after;
        logic       in_comment;
        logic [1:0] error;
    } tok_result_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

`default_nettype wire

// ===== design/forth_source_tokenizer.sv =====
// Top level of the Forth source tokenizer: input register, classifier, result register.
// Depends on ftok_pkg, ftok_in_stage, ftok_classify and ftok_out_stage.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------------
//  src     | src_valid / src_ready | src_byte[7:0], line_end
//  tok     | tok_valid / tok_ready | kind[1:0], starts_token, closes_before,
//          |                       | closes_after, in_comment, error[1:0]
//
// One word per cycle sustained while tok_ready stays high; a taken byte waits in the input
// register, and its result is registered into the result register as the byte moves on. The
// lexer mode updates in that step too, so the mode loop through the classifier sets the rate.
// Reset returns the lexer to idle between tokens and empties both registers.
// A stall on tok backs up through the input register; src_ready drops only when both
// registers are full and tok_ready is low.
`default_nettype none

module forth_source_tokenizer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       src_valid,
    output logic            src_ready,
    input  wire logic [7:0] src_byte,
    input  wire logic       line_end,
    output logic            tok_valid,
    input  wire logic       tok_ready,
    output logic [1:0]      kind,
    output logic            starts_token,
    output logic            closes_before,
    output logic            closes_after,
    output logic            in_comment,
    output logic [1:0]      error
);

    logic                  hold_valid;
    logic [7:0]            hold_byte;
    logic                  hold_le;
    logic                  out_free;
    logic                  advance;
    ftok_pkg::tok_result_t result;

    assign advance = hold_valid && out_free;

    ftok_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .src_byte   (src_byte),
        .line_end   (line_end),
        .take       (advance),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte),
        .hold_le    (hold_le)
    );

    ftok_classify u_cls (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cur_byte (hold_byte),
        .cur_le   (hold_le),
        .result   (result)
    );

    ftok_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .result        (result),
        .free          (out_free),
        .tok_valid     (tok_valid),
        .tok_ready     (tok_ready),
        .kind          (kind),
        .starts_token  (starts_token),
        .closes_before (closes_before),
        .closes_after  (closes_after),
        .in_comment    (in_comment),
        .error         (error)
    );

endmodule

`default_nettype wire

// ===== design/ftok_in_stage.sv =====
// Input register of the tokenizer: captures one source word per cycle while empty or while its held word moves on.
// Depends on nothing but the port signals; no package use.
`default_nettype none

module ftok_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       src_valid,
    output logic            src_ready,
    input  wire logic [7:0] src_byte,
    input  wire logic       line_end,
    input  wire logic       take,
    output logic            hold_valid,
    output logic [7:0]      hold_byte,
    output logic            hold_le
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       le_reg;

    // refill in the same cycle the held word moves on
    assign src_ready  = !valid_reg || take;
    assign valid_next = (src_valid && src_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
        begin
            byte_reg <= src_byte;
            le_reg   <= line_end;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;
    assign hold_le    = le_reg;

endmodule

`default_nettype wire

// ===== design/ftok_classify.sv =====
// Lexer mode register and the per-byte classification logic.
// Uses ftok_pkg for mode codes, byte constants and the result struct.
`default_nettype none

module ftok_classify (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic [7:0]           cur_byte,
    input  wire logic                 cur_le,
    output ftok_pkg::tok_result_t     result
);

    ftok_pkg::lex_mode_t mode_reg;
    ftok_pkg::lex_mode_t mode_next;
    ftok_pkg::lex_mode_t eff_mode;
    logic                ws;

    assign ws = ftok_pkg::is_ws(cur_byte);

    always_comb
    begin
        result    = '0;
        mode_next = mode_reg;
        // whitespace after a closing quote behaves as idle
        eff_mode  = (mode_reg == ftok_pkg::MODE_AFTERSTR) ? ftok_pkg::MODE_IDLE : mode_reg;

        if ((mode_reg == ftok_pkg::MODE_AFTERSTR) && !ws)
        begin
            result.error = ftok_pkg::ERR_NOSPACE;
            mode_next    = ftok_pkg::MODE_HALTED;
        end
        else
        begin
            case (eff_mode)
                ftok_pkg::MODE_IDLE:
                begin
                    if (ws)
                    begin
                        mode_next = ftok_pkg::MODE_IDLE;
                    end
                    else if (cur_byte == ftok_pkg::CH_OPEN)
                    begin
                        result.in_comment = 1'b1;
                        mode_next         = ftok_pkg::MODE_COMMENT;
                    end
                    else if (cur_byte == ftok_pkg::CH_QUOTE)
                    begin
                        result.kind         = ftok_pkg::KIND_STR;
                        result.starts_token = 1'b1;
                        if (cur_le)
                        begin
                            result.error = ftok_pkg::ERR_UNTERM;
                            mode_next    = ftok_pkg::MODE_HALTED;
                        end
                        else
                        begin
                            mode_next = ftok_pkg::MODE_STRING;
                        end
                    end
                    else
                    begin
                        result.kind         = ftok_pkg::KIND_WORD;
                        result.starts_token = 1'b1;
                        result.closes_after = cur_le;
                        mode_next = cur_le ? ftok_pkg::MODE_IDLE : ftok_pkg::MODE_WORD;
                    end
                end
                ftok_pkg::MODE_COMMENT:
                begin
                    if (cur_byte == ftok_pkg::CH_CLOSE)
                    begin
                        mode_next = ftok_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        result.in_comment = 1'b1;
                        mode_next         = ftok_pkg::MODE_COMMENT;
                    end
                end
                ftok_pkg::MODE_WORD:
                begin
                    if (ws)
                    begin
                        result.closes_before = 1'b1;
                        mode_next            = ftok_pkg::MODE_IDLE;
                    end
                    else if (cur_byte == ftok_pkg::CH_OPEN)
                    begin
                        result.closes_before = 1'b1;
                        result.in_comment    = 1'b1;
                        mode_next            = ftok_pkg::MODE_COMMENT;
                    end
                    else
                    begin
                        result.kind         = ftok_pkg::KIND_WORD;
                        result.closes_after = cur_le;
                        mode_next = cur_le ? ftok_pkg::MODE_IDLE : ftok_pkg::MODE_WORD;
                    end
                end
                ftok_pkg::MODE_STRING:
                begin
                    result.kind = ftok_pkg::KIND_STR;
                    if (cur_byte == ftok_pkg::CH_QUOTE)
                    begin
                        result.closes_after = 1'b1;
                        mode_next = cur_le ? ftok_pkg::MODE_IDLE : ftok_pkg::MODE_AFTERSTR;
                    end
                    else if (cur_le)
                    begin
                        result.error = ftok_pkg::ERR_UNTERM;
                        mode_next    = ftok_pkg::MODE_HALTED;
                    end
                    else if (cur_byte == ftok_pkg::CH_BSLASH)
                    begin
                        mode_next = ftok_pkg::MODE_ESC;
                    end
                    else
                    begin
                        mode_next = ftok_pkg::MODE_STRING;
                    end
                end
                ftok_pkg::MODE_ESC:
                begin
                    result.kind = ftok_pkg::KIND_STR;
                    if (cur_le)
                    begin
                        result.error = ftok_pkg::ERR_UNTERM;
                        mode_next    = ftok_pkg::MODE_HALTED;
                    end
                    else
                    begin
                        mode_next = ftok_pkg::MODE_STRING;
                    end
                end
                default:
                begin
                    result.error = ftok_pkg::ERR_HALTED;
                    mode_next    = ftok_pkg::MODE_HALTED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ftok_pkg::MODE_IDLE;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/ftok_out_stage.sv =====
// Result register of the tokenizer with its valid/ready handshake.
// Uses ftok_pkg for the result struct.
`default_nettype none

module ftok_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire ftok_pkg::tok_result_t result,
    output logic                      free,
    output logic                      tok_valid,
    input  wire logic                 tok_ready,
    output logic [1:0]                kind,
    output logic                      starts_token,
    output logic                      closes_before,
    output logic                      closes_after,
    output logic                      in_comment,
    output logic [1:0]                error
);

    logic                  valid_reg;
    logic                  valid_next;
    ftok_pkg::tok_result_t res_reg;

    assign free       = !valid_reg || tok_ready;
    assign valid_next = load || (valid_reg && !tok_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign tok_valid     = valid_reg;
    assign kind          = res_reg.kind;
    assign starts_token  = res_reg.starts_token;
    assign closes_before = res_reg.closes_before;
    assign closes_after  = res_reg.closes_after;
    assign in_comment    = res_reg.in_comment;
    assign error         = res_reg.error;

endmodule

`default_nettype wire

// ===== design/ftok_checker.sv =====
// Port-level checks for the Forth source tokenizer, bound to the top level.
// Depends on ftok_pkg for result and error codes.
`default_nettype none

module ftok_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       tok_valid,
    input wire logic       tok_ready,
    input wire logic [1:0] kind,
    input wire logic       starts_token,
    input wire logic       closes_before,
    input wire logic       closes_after,
    input wire logic       in_comment,
    input wire logic [1:0] error
);

    logic seen_err_reg;

    // any delivered error locks the lexer up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_err_reg <= 1'b0;
        end
        else if (tok_valid && tok_ready && (error != ftok_pkg::ERR_NONE))
        begin
            seen_err_reg <= 1'b1;
        end
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(kind) && $stable(error))
        else $error("result word changed while stalled");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && seen_err_reg |-> error == ftok_pkg::ERR_HALTED)
        else $error("word after an error is not reported as halted");

    a_halt_blank: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (error == ftok_pkg::ERR_HALTED || error == ftok_pkg::ERR_NOSPACE)
        |-> kind == ftok_pkg::KIND_SKIP && !starts_token && !closes_before
            && !closes_after && !in_comment)
        else $error("halted or no-space result carries token fields");

    a_close_before: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && closes_before
        |-> kind == ftok_pkg::KIND_SKIP && !starts_token && !closes_after)
        else $error("word close before a non-skipped byte");

endmodule

bind forth_source_tokenizer ftok_checker u_ftok_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .tok_valid     (tok_valid),
    .tok_ready     (tok_ready),
    .kind          (kind),
    .starts_token  (starts_token),
    .closes_before (closes_before),
    .closes_after  (closes_after),
    .in_comment    (in_comment),
    .error         (error)
);

`default_nettype wire

// ===== tb/forth_source_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for forth_source_tokenizer: directed table, random source text, then one error path.
// Depends on ftok_pkg and the forth_source_tokenizer RTL.

module forth_source_tokenizer_tb;

    localparam int HOLD_CYCLES = 64;
    localparam int RAND_WORDS  = 550;
    localparam int DIR_ROWS    = 25;

    // one directed row: input byte, line flag, and a typed result where one is given
    typedef struct packed {
        logic [7:0]            b;
        logic                  le;
        logic                  typed;
        ftok_pkg::tok_result_t want;
    } lex_row_t;

    localparam ftok_pkg::tok_result_t NO_RESULT = '0;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       src_valid = 1'b0;
    logic       src_ready;
    logic [7:0] src_byte  = 8'h00;
    logic       line_end  = 1'b0;
    logic       tok_valid;
    logic       tok_ready = 1'b0;
    logic [1:0] kind;
    logic       starts_token;
    logic       closes_before;
    logic       closes_after;
    logic       in_comment;
    logic [1:0] error;

    ftok_pkg::tok_result_t pending_tokens[$];
    ftok_pkg::lex_mode_t   lexer_mode = ftok_pkg::MODE_IDLE;
    logic                  row_typed  = 1'b0;
    ftok_pkg::tok_result_t row_want   = '0;
    int                    fails      = 0;
    int                    src_steady = 0;
    bit                    sink_steady = 1'b0;
    bit                    hold_req    = 1'b0;

    forth_source_tokenizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_ready     (src_ready),
        .src_byte      (src_byte),
        .line_end      (line_end),
        .tok_valid     (tok_valid),
        .tok_ready     (tok_ready),
        .kind          (kind),
        .starts_token  (starts_token),
        .closes_before (closes_before),
        .closes_after  (closes_after),
        .in_comment    (in_comment),
        .error         (error)
    );

    always #4 clk = ~clk;

    function automatic bit is_blank(input logic [7:0] b);
        return (b == ftok_pkg::CH_SPACE) || ((b >= ftok_pkg::CH_TAB) && (b <= ftok_pkg::CH_CR));
    endfunction

    function automatic logic [7:0] any_blank();
        if ($urandom_range(0, 1) != 0)
            return ftok_pkg::CH_SPACE;
        return 8'($urandom_range(9, 13));
    endfunction

    // most gaps short, a few long
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // predicted result of one source byte in a given lexer mode
    function automatic ftok_pkg::tok_result_t classify_byte(input ftok_pkg::lex_mode_t mode,
                                                            input logic [7:0] b,
                                                            input logic le,
                                                            output ftok_pkg::lex_mode_t nxt);
        ftok_pkg::tok_result_t r;
        ftok_pkg::lex_mode_t   m;
        r   = '0;
        m   = mode;
        nxt = mode;
        if (m == ftok_pkg::MODE_AFTERSTR && !is_blank(b)) begin
            r.error = ftok_pkg::ERR_NOSPACE;
            nxt     = ftok_pkg::MODE_HALTED;
        end
        else begin
            if (m == ftok_pkg::MODE_AFTERSTR)
                m = ftok_pkg::MODE_IDLE;
            case (m)
                ftok_pkg::MODE_IDLE: begin
                    nxt = ftok_pkg::MODE_IDLE;
                    if (is_blank(b)) begin
                    end
                    else if (b == ftok_pkg::CH_OPEN) begin
                        r.in_comment = 1'b1;
                        nxt          = ftok_pkg::MODE_COMMENT;
                    end
                    else if (b == ftok_pkg::CH_QUOTE) begin
                        r.kind         = ftok_pkg::KIND_STR;
                        r.starts_token = 1'b1;
                        if (le) begin
                            r.error = ftok_pkg::ERR_UNTERM;
                            nxt     = ftok_pkg::MODE_HALTED;
                        end
                        else
                            nxt = ftok_pkg::MODE_STRING;
                    end
                    else begin
                        r.kind         = ftok_pkg::KIND_WORD;
                        r.starts_token = 1'b1;
                        r.closes_after = le;
                        nxt            = le ? ftok_pkg::MODE_IDLE : ftok_pkg::MODE_WORD;
                    end
                end
                ftok_pkg::MODE_COMMENT: begin
                    if (b == ftok_pkg::CH_CLOSE)
                        nxt = ftok_pkg::MODE_IDLE;
                    else
                        r.in_comment = 1'b1;
                end
                ftok_pkg::MODE_WORD: begin
                    if (is_blank(b)) begin
                        r.closes_before = 1'b1;
                        nxt             = ftok_pkg::MODE_IDLE;
                    end
                    else if (b == ftok_pkg::CH_OPEN) begin
                        r.closes_before = 1'b1;
                        r.in_comment    = 1'b1;
                        nxt             = ftok_pkg::MODE_COMMENT;
                    end
                    else begin
                        r.kind         = ftok_pkg::KIND_WORD;
                        r.closes_after = le;
                        nxt            = le ? ftok_pkg::MODE_IDLE : ftok_pkg::MODE_WORD;
                    end
                end
                ftok_pkg::MODE_STRING: begin
                    r.kind = ftok_pkg::KIND_STR;
                    if (b == ftok_pkg::CH_QUOTE) begin
                        r.closes_after = 1'b1;
                        nxt            = le ? ftok_pkg::MODE_IDLE : ftok_pkg::MODE_AFTERSTR;
                    end
                    else if (le) begin
                        r.error = ftok_pkg::ERR_UNTERM;
                        nxt     = ftok_pkg::MODE_HALTED;
                    end
                    else if (b == ftok_pkg::CH_BSLASH)
                        nxt = ftok_pkg::MODE_ESC;
                end
                ftok_pkg::MODE_ESC: begin
                    r.kind = ftok_pkg::KIND_STR;
                    if (le) begin
                        r.error = ftok_pkg::ERR_UNTERM;
                        nxt     = ftok_pkg::MODE_HALTED;
                    end
                    else
                        nxt = ftok_pkg::MODE_STRING;
                end
                default: begin
                    r.error = ftok_pkg::ERR_HALTED;
                    nxt     = ftok_pkg::MODE_HALTED;
                end
            endcase
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fails++;
        end
    endtask

    // offer one word on src; returns at the falling edge after it is taken
    task automatic push_byte(input logic [7:0] b, input logic le, input logic typed,
                             input ftok_pkg::tok_result_t want);
        int gap;
        if (src_steady > 0) begin
            gap = 0;
            src_steady--;
        end
        else
            gap = idle_span();
        if (gap > 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        row_typed = typed;
        row_want  = want;
        src_valid <= 1'b1;
        src_byte  <= b;
        line_end  <= le;
        do
            @(posedge clk);
        while (!src_ready);
        @(negedge clk);
    endtask

    // prediction on acceptance, then check of the result port, in one process
    always @(posedge clk) begin : scoreboard
        ftok_pkg::tok_result_t want;
        ftok_pkg::tok_result_t got;
        ftok_pkg::lex_mode_t   nxt_mode;
        if (rst_n) begin
            if (src_valid && src_ready) begin
                want       = classify_byte(lexer_mode, src_byte, line_end, nxt_mode);
                lexer_mode = nxt_mode;
                if (row_typed)
                    want = row_want;
                pending_tokens.push_back(want);
            end
            if (tok_valid && tok_ready) begin
                if (pending_tokens.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got kind %0d error %0d",
                             $time, kind, error);
                    fails++;
                end
                else begin
                    want = pending_tokens[0];
                    pending_tokens.delete(0);
                    got  = '{kind, starts_token, closes_before, closes_after, in_comment, error};
                    check_field("kind", want.kind, got.kind);
                    check_field("starts_token", want.starts_token, got.starts_token);
                    check_field("closes_before", want.closes_before, got.closes_before);
                    check_field("closes_after", want.closes_after, got.closes_after);
                    check_field("in_comment", want.in_comment, got.in_comment);
                    check_field("error", want.error, got.error);
                end
            end
        end
    end

    // result side: random stalls, steady stretches, one long hold when asked
    initial begin : sink
        int n;
        @(negedge clk);
        forever begin
            if (hold_req) begin
                tok_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (sink_steady) begin
                tok_ready <= 1'b1;
                @(negedge clk);
            end
            else begin
                n = idle_span();
                if (n > 0) begin
                    tok_ready <= 1'b0;
                    repeat (n) @(negedge clk);
                end
                else begin
                    tok_ready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(negedge clk);
                end
            end
        end
    end

    initial begin : stimulus
        lex_row_t              dir_rows [DIR_ROWS];
        ftok_pkg::tok_result_t probe;
        ftok_pkg::lex_mode_t   scratch;
        logic [7:0]            b;
        logic                  le;
        int                    r;
        int                    scenario;

        dir_rows = '{
            {8'h20, 1'b0, 1'b1,
             ftok_pkg::KIND_SKIP, 1'b0, 1'b0, 1'b0, 1'b0, ftok_pkg::ERR_NONE},
            {8'h00, 1'b0, 1'b1,
             ftok_pkg::KIND_WORD, 1'b1, 1'b0, 1'b0, 1'b0, ftok_pkg::ERR_NONE},
            {8'hFF, 1'b0, 1'b1,
             ftok_pkg::KIND_WORD, 1'b0, 1'b0, 1'b0, 1'b0, ftok_pkg::ERR_NONE},
            {ftok_pkg::CH_OPEN, 1'b0, 1'b1,
             ftok_pkg::KIND_SKIP, 1'b0, 1'b1, 1'b0, 1'b1, ftok_pkg::ERR_NONE},
            {ftok_pkg::CH_OPEN, 1'b0, 1'b0, NO_RESULT},
            {8'h0A, 1'b1, 1'b0, NO_RESULT},
            {ftok_pkg::CH_CLOSE, 1'b0, 1'b1,
             ftok_pkg::KIND_SKIP, 1'b0, 1'b0, 1'b0, 1'b0, ftok_pkg::ERR_NONE},
            {ftok_pkg::CH_QUOTE, 1'b0, 1'b1,
             ftok_pkg::KIND_STR, 1'b1, 1'b0, 1'b0, 1'b0, ftok_pkg::ERR_NONE},
            {ftok_pkg::CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
            {ftok_pkg::CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
            {8'hFF, 1'b0, 1'b0, NO_RESULT},
            {ftok_pkg::CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
            {ftok_pkg::CH_TAB, 1'b0, 1'b0, NO_RESULT},
            {ftok_pkg::CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
            {ftok_pkg::CH_QUOTE, 1'b1, 1'b0, NO_RESULT},
            {8'h41, 1'b1, 1'b1,
             ftok_pkg::KIND_WORD, 1'b1, 1'b0, 1'b1, 1'b0, ftok_pkg::ERR_NONE},
            {ftok_pkg::CH_OPEN, 1'b0, 1'b0, NO_RESULT},
            {ftok_pkg::CH_CLOSE, 1'b0, 1'b0, NO_RESULT},
            {8'h7F, 1'b0, 1'b0, NO_RESULT},
            {ftok_pkg::CH_CR, 1'b0, 1'b0, NO_RESULT},
            {8'h08, 1'b0, 1'b0, NO_RESULT},
            {8'h0E, 1'b0, 1'b0, NO_RESULT},
            {ftok_pkg::CH_CLOSE, 1'b0, 1'b0, NO_RESULT},
            {8'h0C, 1'b1, 1'b0, NO_RESULT},
            {ftok_pkg::CH_BSLASH, 1'b1, 1'b0, NO_RESULT}
        };

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            push_byte(dir_rows[i].b, dir_rows[i].le, dir_rows[i].typed, dir_rows[i].want);

        // random text, steered away from errors so the lexer keeps running
        for (int i = 0; i < RAND_WORDS; i++) begin
            if (i == 0 || i == 275) begin
                hold_req   = 1'b1;
                src_steady = 80;
            end
            if (i == 400)
                src_steady = 70;
            sink_steady = (i >= 150 && i < 230);
            r = $urandom_range(0, 99);
            if (r < 30)
                b = 8'($urandom_range(8'h21, 8'h7E));
            else if (r < 45)
                b = any_blank();
            else if (r < 53)
                b = ftok_pkg::CH_OPEN;
            else if (r < 61)
                b = ftok_pkg::CH_CLOSE;
            else if (r < 73)
                b = ftok_pkg::CH_QUOTE;
            else if (r < 81)
                b = ftok_pkg::CH_BSLASH;
            else
                b = 8'($urandom_range(0, 255));
            le = ($urandom_range(0, 7) == 0);
            probe = classify_byte(lexer_mode, b, le, scratch);
            if (probe.error != ftok_pkg::ERR_NONE) begin
                if (lexer_mode == ftok_pkg::MODE_AFTERSTR)
                    b = any_blank();
                else
                    le = 1'b0;
            end
            push_byte(b, le, 1'b0, NO_RESULT);
        end
        sink_steady = 1'b0;

        // back to idle, then one error path picked at random, then halted words
        while (lexer_mode != ftok_pkg::MODE_IDLE) begin
            case (lexer_mode)
                ftok_pkg::MODE_COMMENT:
                    push_byte(ftok_pkg::CH_CLOSE, 1'b0, 1'b0, NO_RESULT);
                ftok_pkg::MODE_STRING:
                    push_byte(ftok_pkg::CH_QUOTE, 1'b1, 1'b0, NO_RESULT);
                ftok_pkg::MODE_ESC:
                    push_byte(8'h61, 1'b0, 1'b0, NO_RESULT);
                default:
                    push_byte(ftok_pkg::CH_SPACE, 1'b0, 1'b0, NO_RESULT);
            endcase
        end
        scenario = $urandom_range(0, 4);
        if (scenario == 0)
            push_byte(ftok_pkg::CH_QUOTE, 1'b1, 1'b1,
                      {ftok_pkg::KIND_STR, 1'b1, 1'b0, 1'b0, 1'b0, ftok_pkg::ERR_UNTERM});
        else begin
            push_byte(ftok_pkg::CH_QUOTE, 1'b0, 1'b0, NO_RESULT);
            case (scenario)
                1: push_byte(8'h61, 1'b1, 1'b1,
                             {ftok_pkg::KIND_STR, 1'b0, 1'b0, 1'b0, 1'b0, ftok_pkg::ERR_UNTERM});
                2: push_byte(ftok_pkg::CH_BSLASH, 1'b1, 1'b1,
                             {ftok_pkg::KIND_STR, 1'b0, 1'b0, 1'b0, 1'b0, ftok_pkg::ERR_UNTERM});
                3: begin
                    push_byte(ftok_pkg::CH_BSLASH, 1'b0, 1'b0, NO_RESULT);
                    push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1,
                              {ftok_pkg::KIND_STR, 1'b0, 1'b0, 1'b0, 1'b0,
                               ftok_pkg::ERR_UNTERM});
                end
                default: begin
                    // closing quote, then a non-blank byte on the same line
                    push_byte(ftok_pkg::CH_QUOTE, 1'b0, 1'b0, NO_RESULT);
                    b = ($urandom_range(0, 1) != 0) ? ftok_pkg::CH_OPEN
                                                    : 8'($urandom_range(8'h21, 8'h7E));
                    push_byte(b, 1'($urandom_range(0, 1)), 1'b1,
                              {ftok_pkg::KIND_SKIP, 1'b0, 1'b0, 1'b0, 1'b0,
                               ftok_pkg::ERR_NOSPACE});
                end
            endcase
        end
        for (int i = 0; i < 12; i++)
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                      {ftok_pkg::KIND_SKIP, 1'b0, 1'b0, 1'b0, 1'b0, ftok_pkg::ERR_HALTED});
        src_valid <= 1'b0;

        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/ftok_pkg.sv
design/ftok_in_stage.sv
design/ftok_classify.sv
design/ftok_out_stage.sv
design/forth_source_tokenizer.sv
design/ftok_checker.sv
tb/forth_source_tokenizer_tb.sv
